// ===== sv/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared constants and types for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	localparam int unsigned FRAMES_DEF = 16;   // default frame count
	localparam int unsigned PAGE_W     = 16;
	localparam int unsigned FRAME_W    = 4;
	localparam int unsigned FAULT_W    = 32;
	localparam int unsigned CFG_W      = 5;

	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

	// control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} lrupr_state_t;

	// update broadcast to the frame cells
	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_TOUCH,   // hit: target becomes most recent
		UPD_FILL,    // miss into an empty frame
		UPD_EVICT    // miss, replace the least recent frame
	} upd_op_t;

	typedef struct packed {
		logic    clear;   // restart: empty every frame
		upd_op_t op;
	} upd_cmd_t;

endpackage

// ===== sv/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// lrupr_cell
// One page frame: page, valid and recency rank, plus one scan carry stage.
// ----------------------------------------------------------------------------
module lrupr_cell import lrupr_pkg::*; #(
	parameter int unsigned FRAMES = FRAMES_DEF,
	parameter int unsigned IDX    = 0,
	parameter int unsigned IW     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              active,
	input  logic [PAGE_W-1:0] probe_page,
	// scan carry from the lower neighbor
	input  logic              hit_f_i,
	input  logic [IW-1:0]     hit_idx_i,
	input  logic [IW-1:0]     hit_rank_i,
	input  logic              emp_f_i,
	input  logic [IW-1:0]     emp_idx_i,
	input  logic              min_f_i,
	input  logic [IW-1:0]     min_idx_i,
	input  logic [IW-1:0]     min_rank_i,
	input  logic [PAGE_W-1:0] min_page_i,
	// scan carry to the upper neighbor
	output logic              hit_f_o,
	output logic [IW-1:0]     hit_idx_o,
	output logic [IW-1:0]     hit_rank_o,
	output logic              emp_f_o,
	output logic [IW-1:0]     emp_idx_o,
	output logic              min_f_o,
	output logic [IW-1:0]     min_idx_o,
	output logic [IW-1:0]     min_rank_o,
	output logic [PAGE_W-1:0] min_page_o,
	// update broadcast
	input  upd_cmd_t          cmd,
	input  logic [IW-1:0]     upd_idx,
	input  logic [IW-1:0]     ref_rank,
	input  logic [IW-1:0]     new_rank
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [PAGE_W-1:0] page_q;
	logic              valid_q;
	logic [IW-1:0]     rank_q;

	logic              hit_f_q, emp_f_q, min_f_q;
	logic [IW-1:0]     hit_idx_q, hit_rank_q, emp_idx_q, min_idx_q, min_rank_q;
	logic [PAGE_W-1:0] min_page_q;

	logic match, empty, is_min, target, load;

	assign match  = active && valid_q && (page_q == probe_page);
	assign empty  = active && !valid_q;
	assign is_min = active && valid_q && (!min_f_i || (rank_q < min_rank_i));
	assign target = (upd_idx == MY_IDX);
	assign load   = !cmd.clear && target && ((cmd.op == UPD_FILL) || (cmd.op == UPD_EVICT));

	// scan carry stage: lowest index wins for hit and empty, strict less for min
	always_ff @(posedge clk) begin
		hit_f_q    <= hit_f_i || match;
		hit_idx_q  <= hit_f_i ? hit_idx_i  : MY_IDX;
		hit_rank_q <= hit_f_i ? hit_rank_i : rank_q;
		emp_f_q    <= emp_f_i || empty;
		emp_idx_q  <= emp_f_i ? emp_idx_i  : MY_IDX;
		min_f_q    <= min_f_i || (active && valid_q);
		min_idx_q  <= is_min ? MY_IDX : min_idx_i;
		min_rank_q <= is_min ? rank_q : min_rank_i;
		min_page_q <= is_min ? page_q : min_page_i;
	end

	assign hit_f_o    = hit_f_q;
	assign hit_idx_o  = hit_idx_q;
	assign hit_rank_o = hit_rank_q;
	assign emp_f_o    = emp_f_q;
	assign emp_idx_o  = emp_idx_q;
	assign min_f_o    = min_f_q;
	assign min_idx_o  = min_idx_q;
	assign min_rank_o = min_rank_q;
	assign min_page_o = min_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else begin
			unique case (cmd.op)
				UPD_TOUCH, UPD_EVICT: begin
					if (target) begin
						rank_q <= new_rank;
					end else if (valid_q && (rank_q > ref_rank)) begin
						rank_q <= rank_q - IW'(1);
					end
				end
				UPD_FILL: begin
					if (target) begin
						rank_q  <= new_rank;
						valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			page_q <= probe_page;
		end
	end

endmodule

// ===== sv/lru_page_replacement_top.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// LRU page replacement over a row of page frame cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall, page, restart): one page reference per
//    transfer. restart empties all frames and zeroes the fault count before
//    the reference is handled.
//  - Output channel (out_valid/out_stall, hit, frame, replaced_valid,
//    replaced_page, fault_count): one result per reference, in order.
//  - cfg_we/cfg_data writes frames_in_use (0 acts as 1, values above FRAMES
//    act as FRAMES). Write only while the block is idle.
//  - Timing: after the accepting edge, a search carry walks the row of
//    FRAMES cells, one cell per cycle, then the update state broadcasts the
//    rank/page changes and registers the result. A new reference is taken
//    only once the block is back in idle, so one reference is handled at a
//    time.
//  - The output register decouples the two sides: the next reference is
//    accepted and searched while a result waits. A stalled receiver only
//    holds the update cycle until the output register is free.
//  - Reset: all frames empty, ranks zero, fault count zero,
//    frames_in_use = 16, no result pending.
// ----------------------------------------------------------------------------
module lru_page_replacement_top import lrupr_pkg::*; #(
	parameter int unsigned FRAMES = FRAMES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_data,
	// reference input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PAGE_W-1:0]  page,
	input  logic               restart,
	// result output
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [FRAME_W-1:0] frame,
	output logic               replaced_valid,
	output logic [PAGE_W-1:0]  replaced_page,
	output logic [FAULT_W-1:0] fault_count
);

	localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;  // index / rank
	localparam int unsigned CW = $clog2(FRAMES + 1);                 // valid count

	lrupr_state_t       state_q, state_nxt;
	logic [IW-1:0]      scan_cnt_q;
	logic [PAGE_W-1:0]  page_q;           // probe held for the whole scan
	logic [CW-1:0]      valid_cnt_q;      // frames valid over the whole row
	logic [FAULT_W-1:0] faults_q;
	logic [CFG_W-1:0]   frames_in_use_q;

	logic               out_valid_q, hit_q, replaced_valid_q;
	logic [FRAME_W-1:0] frame_q;
	logic [PAGE_W-1:0]  replaced_page_q;
	logic [FAULT_W-1:0] fault_count_q;

	logic               accept, fire;
	logic [CW-1:0]      act_cnt;
	logic [FRAMES-1:0]  act_mask;

	upd_cmd_t           cmd;
	logic [IW-1:0]      upd_idx, ref_rank, new_rank;
	logic [FAULT_W-1:0] faults_nxt;
	logic [IW-1:0]      pos;
	logic               res_hit, res_rep;
	logic [PAGE_W-1:0]  res_rep_page;

	// scan carry between neighbor cells; entry 0 is the empty seed
	logic              hit_f_c    [FRAMES+1];
	logic [IW-1:0]     hit_idx_c  [FRAMES+1];
	logic [IW-1:0]     hit_rank_c [FRAMES+1];
	logic              emp_f_c    [FRAMES+1];
	logic [IW-1:0]     emp_idx_c  [FRAMES+1];
	logic              min_f_c    [FRAMES+1];
	logic [IW-1:0]     min_idx_c  [FRAMES+1];
	logic [IW-1:0]     min_rank_c [FRAMES+1];
	logic [PAGE_W-1:0] min_page_c [FRAMES+1];

	assign hit_f_c[0]    = 1'b0;
	assign hit_idx_c[0]  = '0;
	assign hit_rank_c[0] = '0;
	assign emp_f_c[0]    = 1'b0;
	assign emp_idx_c[0]  = '0;
	assign min_f_c[0]    = 1'b0;
	assign min_idx_c[0]  = '0;
	assign min_rank_c[0] = '0;
	assign min_page_c[0] = '0;

	// active frame count, clamped to 1..FRAMES
	always_comb begin
		if (frames_in_use_q == '0) begin
			act_cnt = CW'(1);
		end else if (32'(frames_in_use_q) > FRAMES) begin
			act_cnt = CW'(FRAMES);
		end else begin
			act_cnt = CW'(frames_in_use_q);
		end
	end

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		assign act_mask[g] = (CW'(g) < act_cnt);

		lrupr_cell #(
			.FRAMES (FRAMES),
			.IDX    (g),
			.IW     (IW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.active     (act_mask[g]),
			.probe_page (page_q),
			.hit_f_i    (hit_f_c[g]),
			.hit_idx_i  (hit_idx_c[g]),
			.hit_rank_i (hit_rank_c[g]),
			.emp_f_i    (emp_f_c[g]),
			.emp_idx_i  (emp_idx_c[g]),
			.min_f_i    (min_f_c[g]),
			.min_idx_i  (min_idx_c[g]),
			.min_rank_i (min_rank_c[g]),
			.min_page_i (min_page_c[g]),
			.hit_f_o    (hit_f_c[g+1]),
			.hit_idx_o  (hit_idx_c[g+1]),
			.hit_rank_o (hit_rank_c[g+1]),
			.emp_f_o    (emp_f_c[g+1]),
			.emp_idx_o  (emp_idx_c[g+1]),
			.min_f_o    (min_f_c[g+1]),
			.min_idx_o  (min_idx_c[g+1]),
			.min_rank_o (min_rank_c[g+1]),
			.min_page_o (min_page_c[g+1]),
			.cmd        (cmd),
			.upd_idx    (upd_idx),
			.ref_rank   (ref_rank),
			.new_rank   (new_rank)
		);
	end

	// decision from the carry leaving the last cell
	always_comb begin
		res_hit      = hit_f_c[FRAMES];
		res_rep      = 1'b0;
		res_rep_page = '0;
		if (hit_f_c[FRAMES]) begin
			pos = hit_idx_c[FRAMES];
		end else if (emp_f_c[FRAMES]) begin
			pos = emp_idx_c[FRAMES];
		end else begin
			pos          = min_idx_c[FRAMES];
			res_rep      = 1'b1;
			res_rep_page = min_page_c[FRAMES];
		end
		if (!res_hit && (faults_q != '1)) begin
			faults_nxt = faults_q + FAULT_W'(1);
		end else begin
			faults_nxt = faults_q;
		end
	end

	// sequencer: next state and update broadcast
	always_comb begin
		state_nxt = state_q;
		in_stall  = (state_q != ST_IDLE);
		accept    = in_valid && !in_stall;
		fire      = 1'b0;
		cmd.clear = 1'b0;
		cmd.op    = UPD_NONE;
		upd_idx   = pos;
		ref_rank  = hit_f_c[FRAMES] ? hit_rank_c[FRAMES] : min_rank_c[FRAMES];
		new_rank  = IW'(valid_cnt_q - CW'(1));
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.clear = restart;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_cnt_q == IW'(FRAMES - 1)) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!out_valid_q || !out_stall) begin
					fire      = 1'b1;
					state_nxt = ST_IDLE;
					if (hit_f_c[FRAMES]) begin
						cmd.op = UPD_TOUCH;
					end else if (emp_f_c[FRAMES]) begin
						cmd.op   = UPD_FILL;
						new_rank = IW'(valid_cnt_q);
					end else begin
						cmd.op = UPD_EVICT;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q      <= '0;
			valid_cnt_q     <= '0;
			faults_q        <= '0;
			frames_in_use_q <= FRAMES_IN_USE_RST;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				frames_in_use_q <= cfg_data;
			end
			if (accept) begin
				scan_cnt_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + IW'(1);
			end
			if (accept && restart) begin
				valid_cnt_q <= '0;
				faults_q    <= '0;
			end else if (fire) begin
				faults_q <= faults_nxt;
				if (cmd.op == UPD_FILL) begin
					valid_cnt_q <= valid_cnt_q + CW'(1);
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// probe and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= page;
		end
		if (fire) begin
			hit_q            <= res_hit;
			frame_q          <= FRAME_W'(pos);
			replaced_valid_q <= res_rep;
			replaced_page_q  <= res_rep_page;
			fault_count_q    <= faults_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign frame          = frame_q;
	assign replaced_valid = replaced_valid_q;
	assign replaced_page  = replaced_page_q;
	assign fault_count    = fault_count_q;

endmodule

// ===== sv/lrupr_checker.sv =====
// ----------------------------------------------------------------------------
// lrupr_checker
// Port-level checks for lru_page_replacement_top, attached by bind.
// ----------------------------------------------------------------------------
module lrupr_checker import lrupr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               hit,
	input logic [FRAME_W-1:0] frame,
	input logic               replaced_valid,
	input logic [PAGE_W-1:0]  replaced_page,
	input logic [FAULT_W-1:0] fault_count
);

	// a stalled result holds until transferred
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(frame)
			&& $stable(replaced_valid) && $stable(replaced_page)
			&& $stable(fault_count))
		else $error("result changed while stalled");

	// one reference in flight: input stalls right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second reference taken during search");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !replaced_valid)
		else $error("eviction reported on hit");

	// no eviction means no evicted page
	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !replaced_valid |-> replaced_page == '0)
		else $error("replaced page nonzero without eviction");

	// a fault always leaves a nonzero count
	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> fault_count != '0)
		else $error("fault not counted");

endmodule

bind lru_page_replacement_top lrupr_checker u_lrupr_checker (.*);

// ===== tb/sv/lru_page_replacement_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_page_replacement_top_test
// Self-checking bench for the LRU page replacement block. A frame table
// tracker predicts hit, frame, evicted page and fault count for every
// accepted page reference and checks the results in order. Directed
// references cover empty and full tables, shrinking and growing frame
// counts, duplicate pages and restarts. Random streams over a small working
// set, with random idling on both channels, follow.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic                          hit;
	logic [lrupr_pkg::FRAME_W-1:0] frame;
	logic                          replaced_valid;
	logic [lrupr_pkg::PAGE_W-1:0]  replaced_page;
	logic [lrupr_pkg::FAULT_W-1:0] fault_count;
} page_result_t;

// Frame table tracker: its own copy of the frames, ranks and fault count,
// plus the queue of results still owed by the block.
class lru_frame_table;
	logic [lrupr_pkg::PAGE_W-1:0]  frame_pg [lrupr_pkg::FRAMES_DEF];
	bit                            frame_used [lrupr_pkg::FRAMES_DEF];
	logic [3:0]                    age_rank [lrupr_pkg::FRAMES_DEF] = '{default: '0};
	logic [lrupr_pkg::FAULT_W-1:0] faults = '0;
	logic [lrupr_pkg::CFG_W-1:0]   frames_cfg = lrupr_pkg::FRAMES_IN_USE_RST;
	page_result_t                  due[$];
	int unsigned                   mismatches = 0;
	int unsigned                   checked = 0;

	function int unsigned used_frames();
		int unsigned n;
		n = 0;
		foreach (frame_used[i])
			if (frame_used[i])
				n++;
		return n;
	endfunction

	// frame f becomes the most recent one
	function void promote(int unsigned f);
		int unsigned r, v;
		r = age_rank[f];
		v = used_frames();
		foreach (age_rank[i])
			if (frame_used[i] && age_rank[i] > r)
				age_rank[i]--;
		age_rank[f] = 4'(v - 1);
	endfunction

	function int unsigned active_frames();
		if (frames_cfg < 1)
			return 1;
		if (frames_cfg > lrupr_pkg::FRAMES_DEF)
			return lrupr_pkg::FRAMES_DEF;
		return frames_cfg;
	endfunction

	function void take_reference(logic [lrupr_pkg::PAGE_W-1:0] pg, bit rs);
		int unsigned act, pos, oldest;
		bit found, empty, have_old;
		page_result_t want;
		act = active_frames();
		want = '0;
		if (rs) begin
			foreach (frame_used[i]) begin
				frame_used[i] = 0;
				age_rank[i] = '0;
			end
			faults = '0;
		end
		found = 0;
		pos = 0;
		for (int unsigned i = 0; i < act; i++)
			if (!found && frame_used[i] && frame_pg[i] == pg) begin
				found = 1;
				pos = i;
			end
		if (found) begin
			promote(pos);
		end else begin
			empty = 0;
			have_old = 0;
			oldest = 0;
			for (int unsigned i = 0; i < act; i++) begin
				if (!empty) begin
					if (!frame_used[i]) begin
						pos = i;
						empty = 1;
					end else if (!have_old || age_rank[i] < oldest) begin
						have_old = 1;
						oldest = age_rank[i];
						pos = i;
					end
				end
			end
			if (empty) begin
				age_rank[pos] = 4'(used_frames());
				frame_used[pos] = 1;
				frame_pg[pos] = pg;
			end else begin
				want.replaced_valid = 1'b1;
				want.replaced_page = frame_pg[pos];
				frame_pg[pos] = pg;
				promote(pos);
			end
			if (faults != '1)
				faults++;
		end
		want.hit = found;
		want.frame = pos[lrupr_pkg::FRAME_W-1:0];
		want.fault_count = faults;
		due.push_back(want);
	endfunction

	task report_mismatch(string msg);
		mismatches++;
		$display("mismatch at result %0d: %s", checked, msg);
	endtask

	task check_result(page_result_t got);
		page_result_t want;
		checked++;
		if (due.size() == 0) begin
			report_mismatch("result with no reference outstanding");
			return;
		end
		want = due.pop_front();
		if (got.hit !== want.hit)
			report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
		if (got.frame !== want.frame)
			report_mismatch($sformatf("frame %0d, want %0d", got.frame, want.frame));
		if (got.replaced_valid !== want.replaced_valid)
			report_mismatch($sformatf("replaced_valid %b, want %b",
				got.replaced_valid, want.replaced_valid));
		if (got.replaced_page !== want.replaced_page)
			report_mismatch($sformatf("replaced_page %h, want %h",
				got.replaced_page, want.replaced_page));
		if (got.fault_count !== want.fault_count)
			report_mismatch($sformatf("fault_count %0d, want %0d",
				got.fault_count, want.fault_count));
	endtask

	function int unsigned pending();
		return due.size();
	endfunction
endclass

module lru_page_replacement_top_test;
	import lrupr_pkg::*;

	// Cycles a single reference can take inside the block: the search walks
	// every frame cell, then the update state, then the output register.
	localparam int unsigned REF_CYCLES   = FRAMES_DEF + 2;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned SEG_ITEMS    = 325;
	localparam int unsigned SEGMENTS     = 6;

	// Idling profiles, in run order.
	typedef enum logic [1:0] {
		PACE_SLOW_SINK,   // sender idles a little, receiver a lot
		PACE_SLOW_SRC,    // the other way round
		PACE_FULL         // nobody idles
	} pace_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [PAGE_W-1:0]  page = '0;
	logic               restart = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               hit;
	logic [FRAME_W-1:0] frame;
	logic               replaced_valid;
	logic [PAGE_W-1:0]  replaced_page;
	logic [FAULT_W-1:0] fault_count;

	lru_frame_table     sb;
	int unsigned        src_pct = 0;
	int unsigned        sink_pct = 0;
	int unsigned        hold_left = 0;
	bit                 held_once = 0;
	page_result_t       seen;

	lru_page_replacement_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.page           (page),
		.restart        (restart),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.frame          (frame),
		.replaced_valid (replaced_valid),
		.replaced_page  (replaced_page),
		.fault_count    (fault_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side. Values read right after the edge are the ones the block
	// saw at that edge, so a transfer is out_valid && !out_stall here.
	// Once, after 100 results, the receiver holds off for a long stretch so
	// the output register and the search fill up and in_stall rises while
	// the sender keeps offering references.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen = {hit, frame, replaced_valid, replaced_page, fault_count};
			sb.check_result(seen);
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!held_once && arst_n && sb.checked >= 100) begin
			held_once = 1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_pct);
		end
	end

	// Watchdog: the whole run must end well within the limit.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	task automatic set_pace(input pace_t p);
		case (p)
			PACE_SLOW_SINK: begin
				src_pct = 19;
				sink_pct = 76;
			end
			PACE_SLOW_SRC: begin
				src_pct = 76;
				sink_pct = 19;
			end
			default: begin
				src_pct = 0;
				sink_pct = 0;
			end
		endcase
	endtask

	// Offer one reference and hold it until the transfer. Called right
	// after a rising edge; valid stays up when no gap follows.
	task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic rs);
		int unsigned gap;
		in_valid <= 1'b1;
		page <= pg;
		restart <= rs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_reference(pg, rs);
		gap = 0;
		while (gap < 40 && $urandom_range(99) < src_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Every reference yields a result, so the block is idle once nothing is
	// owed; the extra cycles just cover the update and output stages.
	task automatic wait_idle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (REF_CYCLES + 4) @(posedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.frames_cfg = v;
	endtask

	initial begin
		logic [PAGE_W-1:0] pg_base;
		logic [PAGE_W-1:0] pg;
		int unsigned       ws;
		logic [CFG_W-1:0]  seg_cfg;

		sb = new;
		set_pace(PACE_FULL);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// Four frames: fill from empty, hit, then evict the least recent.
		write_frames(5'd4);
		send_ref(16'h0000, 1'b1);
		send_ref(16'hFFFF, 1'b0);
		send_ref(16'h0000, 1'b0);
		send_ref(16'h5555, 1'b0);
		send_ref(16'hAAAA, 1'b0);
		send_ref(16'h1234, 1'b0);   // evicts FFFF from frame 1
		send_ref(16'h0000, 1'b0);

		// Zero frames acts as one: AAAA now also sits in frame 0 while the
		// inactive frame 3 keeps its copy.
		write_frames(5'd0);
		send_ref(16'hAAAA, 1'b0);
		send_ref(16'hAAAA, 1'b0);

		// Grow past the frame count: duplicate hits the lower frame, the
		// inactive frames rejoin the recency order.
		write_frames(5'd31);
		send_ref(16'hAAAA, 1'b0);
		send_ref(16'h5555, 1'b0);
		send_ref(16'h0F0F, 1'b0);
		send_ref(16'hF0F0, 1'b0);

		// One frame: every new page evicts the only one.
		write_frames(5'd1);
		send_ref(16'h8001, 1'b0);
		send_ref(16'h7FFE, 1'b0);
		send_ref(16'h7FFE, 1'b0);

		// Count just above the frame total, then restart on a reference.
		write_frames(5'd17);
		send_ref(16'h00FF, 1'b0);
		send_ref(16'hFF00, 1'b1);
		send_ref(16'h00FF, 1'b0);
		send_ref(16'hFF00, 1'b0);

		// --- random ---
		// Mostly references into a working set of the active frames plus up to
		// four pages, so hits, fills and evictions all happen; a few
		// stray pages and rare restarts on top.
		pg_base = 16'($urandom);
		for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: seg_cfg = 5'd16;
				1: seg_cfg = 5'd1;
				2: seg_cfg = 5'd31;
				3: seg_cfg = 5'd0;
				4: seg_cfg = 5'($urandom_range(2, 15));
				default: seg_cfg = 5'($urandom_range(17, 30));
			endcase
			write_frames(seg_cfg);
			if (seg < 2)
				set_pace(PACE_SLOW_SINK);
			else if (seg < 4)
				set_pace(PACE_SLOW_SRC);
			else
				set_pace(PACE_FULL);
			if ($urandom_range(1) == 1)
				pg_base = 16'($urandom);
			ws = sb.active_frames() + $urandom_range(0, 4);
			for (int unsigned n = 0; n < SEG_ITEMS; n++) begin
				if ($urandom_range(99) < 8)
					pg = 16'($urandom_range(16'hFFFF));
				else
					pg = pg_base + 16'($urandom_range(0, ws - 1));
				send_ref(pg, $urandom_range(199) < 3);
			end
		end

		in_valid <= 1'b0;
		wait_idle();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0 && held_once)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
